FILE: rtl/jssl_pkg.sv
package jssl_pkg;

    localparam int ANGLE_W  = 20;
    localparam int ALPHA_W  = 16;
    localparam int VEL_W    = 20;
    localparam int PERIOD_W = 16;

    localparam int DEF_ARM_COUNT      = 2;
    localparam int DEF_JOINTS_PER_ARM = 7;

    // config port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING_WEIGHT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_VELOCITY     = 1'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd9830;
    localparam logic [VEL_W-1:0]   VEL_RESET   = 20'd131072;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 16'd328;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'd32768;

    // round(2^40 / 1e6)
    localparam int RECIP_W = 21;
    localparam logic [RECIP_W-1:0] RECIP_1E6 = 21'd1099512;

    localparam logic signed [ANGLE_W+1:0] ANGLE_MAX = 22'sd524287;
    localparam logic signed [ANGLE_W+1:0] ANGLE_MIN = -22'sd524288;

    // shared multiplier operand widths
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // velocity * period product is split at this bit for the reciprocal multiply
    localparam int PROD_W  = VEL_W + PERIOD_W;
    localparam int SPLIT   = 18;
    localparam int MDELTA_W = 18;
    // reciprocal times upper half, and the shift left over after the split
    localparam int RHI_P_W  = RECIP_W + PROD_W - SPLIT;
    localparam int MD_SHIFT = 40 - SPLIT;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_SEED   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_VEL,
        S_RLO,
        S_RHI,
        S_MD,
        S_ARM,
        S_MUL,
        S_CALC
    } state_t;

endpackage

FILE: rtl/jssl_mul.sv
module jssl_mul (
    input  logic                                 aclk,
    input  logic signed [jssl_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [jssl_pkg::MUL_B_W-1:0] op_b,
    output logic signed [jssl_pkg::MUL_P_W-1:0] prod_reg
);
    import jssl_pkg::*;

    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

FILE: rtl/joint_smoothing_slew_limiter_top.sv
// Joint command smoother with slew limit. Each joint's command moves toward its
// target by alpha (Q1.15) per tick, then the step is clamped to
// max_velocity * period_us / 1e6 and saturated to the Q3.16 angle range. All
// products go through one registered multiplier under a small sequencer, and
// the block takes no new item until the current one is done. A target item is
// stored in the decode state; a seed item also loads a result there and waits
// while the result port stalls. A tick first forms the step limit with three
// multiplies, then checks each arm in turn, and for each joint of a valid arm
// multiplies, then clamps and writes back; a stalled result port holds the tick.
module joint_smoothing_slew_limiter_top #(
    parameter int ARM_COUNT      = jssl_pkg::DEF_ARM_COUNT,
    parameter int JOINTS_PER_ARM = jssl_pkg::DEF_JOINTS_PER_ARM
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config
    input  logic                                cfg_wr_en,
    input  logic [jssl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [jssl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // arm_index[0], joint_index[3:1], angle_value[23:4], period_us[39:24]
    input  logic [39:0]                         s_tdata,
    // kind[1:0]
    input  logic [1:0]                          s_tuser,
    // set_complete
    input  logic                                s_tlast,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_arm[0], out_joint[3:1], command_angle[23:4]
    output logic [23:0]                         m_tdata,
    // last_command
    output logic                                m_tlast
);
    import jssl_pkg::*;

    localparam int TOTAL = ARM_COUNT * JOINTS_PER_ARM;
    localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int ARM_W = (ARM_COUNT > 1) ? $clog2(ARM_COUNT) : 1;
    localparam int JNT_W = (JOINTS_PER_ARM > 1) ? $clog2(JOINTS_PER_ARM) : 1;

    state_t state_reg, state_next;

    logic [ALPHA_W-1:0] weight_reg;
    logic [VEL_W-1:0]   max_vel_reg;

    logic signed [ANGLE_W-1:0] smooth_reg [TOTAL];
    logic signed [ANGLE_W-1:0] tgt_reg    [TOTAL];
    logic [ARM_COUNT-1:0]      arm_valid_reg;

    logic [ARM_W-1:0] arm_reg;
    logic [JNT_W-1:0] joint_reg;

    // captured item
    kind_t                     item_kind_reg;
    logic                      item_arm_reg;
    logic [2:0]                item_joint_reg;
    logic signed [ANGLE_W-1:0] item_angle_reg;
    logic                      item_done_reg;
    logic [PERIOD_W-1:0]       item_period_reg;

    logic [PROD_W-SPLIT-1:0] prod_hi_reg;
    logic [RECIP_W-1:0]      lo_reg;
    logic [MDELTA_W-1:0]     mdelta_reg;

    logic                      m_tvalid_reg;
    logic                      out_arm_reg;
    logic [2:0]                out_joint_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic                      out_last_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic s_acc;
    logic out_free;
    logic out_load;
    logic item_ok;
    logic arm_last;
    logic joint_last;
    logic valid_above;
    logic calc_last;

    logic [IDX_W-1:0]          idx;
    logic [IDX_W-1:0]          item_idx;
    logic signed [ANGLE_W-1:0] cur;
    logic signed [ANGLE_W-1:0] tgt;
    logic signed [ANGLE_W:0]   diff;
    logic [ALPHA_W-1:0]        alpha_eff;
    logic [RHI_P_W:0]          md_sum;
    logic signed [MUL_P_W-1:0] round_sum;
    logic signed [ANGLE_W+1:0] delta;
    logic signed [ANGLE_W+1:0] md_s;
    logic signed [ANGLE_W+1:0] dcl;
    logic signed [ANGLE_W+1:0] new_sum;
    logic signed [ANGLE_W-1:0] new_angle;

    jssl_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_angle_reg, out_joint_reg, out_arm_reg};
    assign m_tlast  = out_last_reg;

    assign item_ok  = (int'(item_arm_reg) < ARM_COUNT) &&
                      (int'(item_joint_reg) < JOINTS_PER_ARM);
    assign item_idx = IDX_W'(int'(item_arm_reg) * JOINTS_PER_ARM + int'(item_joint_reg));
    assign idx      = IDX_W'(int'(arm_reg) * JOINTS_PER_ARM + int'(joint_reg));

    assign arm_last   = (arm_reg == ARM_W'(ARM_COUNT - 1));
    assign joint_last = (joint_reg == JNT_W'(JOINTS_PER_ARM - 1));

    always_comb begin
        valid_above = 1'b0;
        for (int k = 0; k < ARM_COUNT; k++) begin
            if (k > int'(arm_reg) && arm_valid_reg[k]) begin
                valid_above = 1'b1;
            end
        end
    end

    assign calc_last = joint_last && !valid_above;

    always_comb begin
        if (weight_reg < ALPHA_MIN) begin
            alpha_eff = ALPHA_MIN;
        end else if (weight_reg > ALPHA_ONE) begin
            alpha_eff = ALPHA_ONE;
        end else begin
            alpha_eff = weight_reg;
        end
    end

    assign cur  = smooth_reg[idx];
    assign tgt  = tgt_reg[idx];
    assign diff = {tgt[ANGLE_W-1], tgt} - {cur[ANGLE_W-1], cur};

    // max step = (hi * R * 2^18 + lo * R) >> 40 = (hi * R + (lo * R >> 18)) >> 22
    assign md_sum = {1'b0, prod[RHI_P_W-1:0]}
                    + {{(RHI_P_W+1-RECIP_W){1'b0}}, lo_reg};

    // alpha * (target - smoothed), rounded, is the unlimited step
    assign round_sum = prod + MUL_P_W'(16384);
    assign delta     = round_sum[ANGLE_W+16:15];
    assign md_s      = {{(ANGLE_W+2-MDELTA_W){1'b0}}, mdelta_reg};

    always_comb begin
        if (delta > md_s) begin
            dcl = md_s;
        end else if (delta < -md_s) begin
            dcl = -md_s;
        end else begin
            dcl = delta;
        end
    end

    assign new_sum = {{2{cur[ANGLE_W-1]}}, cur} + dcl;

    always_comb begin
        if (new_sum > ANGLE_MAX) begin
            new_angle = ANGLE_MAX[ANGLE_W-1:0];
        end else if (new_sum < ANGLE_MIN) begin
            new_angle = ANGLE_MIN[ANGLE_W-1:0];
        end else begin
            new_angle = new_sum[ANGLE_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (item_kind_reg)
                    KIND_TICK:   state_next = S_VEL;
                    KIND_TARGET: state_next = S_IDLE;
                    KIND_SEED: begin
                        if (!item_ok || out_free) state_next = S_IDLE;
                    end
                    default:     state_next = S_IDLE;
                endcase
            end
            S_VEL: state_next = S_RLO;
            S_RLO: state_next = S_RHI;
            S_RHI: state_next = S_MD;
            S_MD:  state_next = S_ARM;
            S_ARM: begin
                if (arm_valid_reg[arm_reg]) begin
                    state_next = S_MUL;
                end else if (arm_last) begin
                    state_next = S_IDLE;
                end
            end
            S_MUL: state_next = S_CALC;
            S_CALC: begin
                if (out_free) begin
                    if (!joint_last) begin
                        state_next = S_MUL;
                    end else if (arm_last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_ARM;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier operands and result load
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        out_load = 1'b0;
        case (state_reg)
            S_DECODE: begin
                out_load = (item_kind_reg == KIND_SEED) && item_ok && out_free;
            end
            S_VEL: begin
                mul_a = {{(MUL_A_W-VEL_W){1'b0}}, max_vel_reg};
                mul_b = {{(MUL_B_W-PERIOD_W){1'b0}}, item_period_reg};
            end
            S_RLO: begin
                mul_a = {{(MUL_A_W-RECIP_W){1'b0}}, RECIP_1E6};
                mul_b = {{(MUL_B_W-SPLIT){1'b0}}, prod[SPLIT-1:0]};
            end
            S_RHI: begin
                mul_a = {{(MUL_A_W-RECIP_W){1'b0}}, RECIP_1E6};
                mul_b = {{(MUL_B_W-PROD_W+SPLIT){1'b0}}, prod_hi_reg};
            end
            S_MUL: begin
                mul_a = {diff[ANGLE_W], diff};
                mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff};
            end
            S_CALC: begin
                // keep the joint's product alive while the result port stalls
                mul_a    = {diff[ANGLE_W], diff};
                mul_b    = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff};
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // control and state storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            weight_reg    <= ALPHA_RESET;
            max_vel_reg   <= VEL_RESET;
            arm_valid_reg <= '0;
            arm_reg       <= '0;
            joint_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < TOTAL; i++) begin
                smooth_reg[i] <= '0;
                tgt_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SMOOTHING_WEIGHT: weight_reg  <= cfg_wdata[ALPHA_W-1:0];
                    REG_MAX_VELOCITY:     max_vel_reg <= cfg_wdata[VEL_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (state_reg == S_DECODE && item_ok) begin
                if (item_kind_reg == KIND_TARGET) begin
                    tgt_reg[item_idx] <= item_angle_reg;
                    if (item_done_reg) arm_valid_reg[ARM_W'(item_arm_reg)] <= 1'b1;
                end else if (item_kind_reg == KIND_SEED && out_free) begin
                    tgt_reg[item_idx]    <= item_angle_reg;
                    smooth_reg[item_idx] <= item_angle_reg;
                    arm_valid_reg[ARM_W'(item_arm_reg)] <= 1'b0;
                end
            end

            if (state_reg == S_MD) begin
                arm_reg   <= '0;
                joint_reg <= '0;
            end

            if (state_reg == S_ARM && !arm_valid_reg[arm_reg] && !arm_last) begin
                arm_reg <= arm_reg + 1'b1;
            end

            if (state_reg == S_CALC && out_free) begin
                smooth_reg[idx] <= new_angle;
                if (joint_last) begin
                    joint_reg <= '0;
                    if (!arm_last) arm_reg <= arm_reg + 1'b1;
                end else begin
                    joint_reg <= joint_reg + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            item_kind_reg   <= kind_t'(s_tuser);
            item_arm_reg    <= s_tdata[0];
            item_joint_reg  <= s_tdata[3:1];
            item_angle_reg  <= s_tdata[23:4];
            item_period_reg <= s_tdata[39:24];
            item_done_reg   <= s_tlast;
        end
        if (state_reg == S_RLO) begin
            prod_hi_reg <= prod[PROD_W-1:SPLIT];
        end
        if (state_reg == S_RHI) begin
            lo_reg <= prod[SPLIT+RECIP_W-1:SPLIT];
        end
        if (state_reg == S_MD) begin
            mdelta_reg <= md_sum[MD_SHIFT+MDELTA_W-1:MD_SHIFT];
        end
        if (out_load) begin
            if (state_reg == S_CALC) begin
                out_arm_reg   <= arm_reg[0];
                out_joint_reg <= 3'(joint_reg);
                out_angle_reg <= new_angle;
                out_last_reg  <= calc_last;
            end else begin
                out_arm_reg   <= item_arm_reg;
                out_joint_reg <= item_joint_reg;
                out_angle_reg <= item_angle_reg;
                out_last_reg  <= 1'b1;
            end
        end
    end

    // product feeding the clamp comes from the joint's own multiply
    a_calc_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC) |-> ($past(state_reg) == S_MUL || $past(state_reg) == S_CALC))
        else $error("clamp stage entered without a joint multiply");

    a_step_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC) |-> (dcl <= md_s && dcl >= -md_s))
        else $error("joint step exceeds slew limit");

    // only invalid arms may still be scanned after the final command
    a_last_ends_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC && out_free && calc_last)
        |=> (state_reg == S_IDLE || state_reg == S_ARM))
        else $error("tick continued after its final command");

    a_valid_stable_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ARM || state_reg == S_MUL || state_reg == S_CALC)
        |=> $stable(arm_valid_reg))
        else $error("arm valid marks changed during a tick");

    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC && !out_free) |=> (state_reg == S_CALC && !s_tready))
        else $error("sequencer moved while a result was blocked");

endmodule
